[hdl/bpps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bpps_pkg;

    // Default coordinate width (signed Q8.8 points).
    localparam int COORD_WIDTH_DEF = 16;
    localparam int NORMAL_W        = 16;

    // Reciprocal square root iteration.
    localparam int          NEWTON_STEPS = 4;
    localparam logic [15:0] THREE_HALVES = 16'd49152;
    localparam logic [15:0] SEED_LT_29   = 16'd26214;
    localparam logic [15:0] SEED_LT_30   = 16'd19661;
    localparam logic [15:0] SEED_LT_31   = 16'd13926;
    localparam logic [15:0] SEED_HIGH    = 16'd10650;
    localparam logic [15:0] UNIT_Q14     = 16'd16384;

    // Shading constants.
    localparam int          SPEC_POWER = 14;
    localparam logic [16:0] SPEC_CAP   = 17'd65536;
    localparam logic [7:0]  SPEC_SCALE = 8'd150;
    // x / 5 == (x * RECIP5) >> 34 for every 32-bit x.
    localparam logic [31:0] RECIP5     = 32'hCCCC_CCCD;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] COLOR_RESET = 8'd100;

    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_RED   = 2'd0;
    localparam cfg_index_t CFG_GREEN = 2'd1;
    localparam cfg_index_t CFG_BLUE  = 2'd2;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } color_t;

    // Ambient term floor(c * 2^14 / 5). 2^14 = 5 * 3276 + 4, and the small
    // remainder part (4c) / 5 uses (x * 205) >> 10, exact for x below 1024.
    function automatic logic [19:0] color_base(input logic [7:0] c);
        logic [19:0] whole;
        logic [19:0] frac;
        whole = 20'(c) * 20'd3276;
        frac  = (20'(c) * 20'd820) >> 10;
        return whole + frac;
    endfunction

endpackage

`default_nettype wire

[hdl/bpps_front.sv]
`timescale 1ns / 1ps
`default_nettype none

// Input register: takes a pixel transaction and forms the light and view
// direction vectors relative to the shaded point.
module bpps_front #(
    parameter int COORD_WIDTH = bpps_pkg::COORD_WIDTH_DEF,
    parameter int IN_W        = 48,
    parameter int FE_W        = 48
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [IN_W-1:0] s_tdata,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [FE_W-1:0]      out_data
);

    localparam int NW  = bpps_pkg::NORMAL_W;
    localparam int DW  = COORD_WIDTH + 1;
    localparam int SRF = 3 * NW;
    localparam int LGT = SRF + 3 * COORD_WIDTH;
    localparam int CAM = LGT + 3 * COORD_WIDTH;

    logic            valid_reg;
    logic [FE_W-1:0] data_reg;
    logic [FE_W-1:0] data_next;

    always_comb
    begin
        data_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            logic signed [DW-1:0] surf;
            logic signed [DW-1:0] lgt;
            logic signed [DW-1:0] cam;
            surf = DW'($signed(s_tdata[SRF + COORD_WIDTH*i +: COORD_WIDTH]));
            lgt  = DW'($signed(s_tdata[LGT + COORD_WIDTH*i +: COORD_WIDTH]));
            cam  = DW'($signed(s_tdata[CAM + COORD_WIDTH*i +: COORD_WIDTH]));
            data_next[NW*i +: NW]              = s_tdata[NW*i +: NW];
            data_next[3*NW + DW*i +: DW]       = lgt - surf;
            data_next[3*NW + 3*DW + DW*i +: DW] = cam - surf;
        end
    end

    assign s_tready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

[hdl/bpps_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

// Small queue between the input register and the shading pipeline.
module bpps_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bpps_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != (AW+1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (AW+1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (AW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

[hdl/bpps_norm.sv]
`timescale 1ns / 1ps
`default_nettype none

// Pipelined vector normalizer: block-scales the magnitudes into [2^14, 2^15),
// finds 1/sqrt of the squared length by Newton steps and scales back to Q1.14.
// A side tag travels with each vector.
module bpps_norm #(
    parameter int IN_W  = 17,
    parameter int TAG_W = 1
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic [2:0][IN_W-1:0]  in_vec,
    input  wire logic [TAG_W-1:0]      in_tag,
    output logic                       out_valid,
    output logic [2:0][15:0]           out_vec,
    output logic [TAG_W-1:0]           out_tag
);

    localparam int PW = $clog2(IN_W);
    localparam int NS = bpps_pkg::NEWTON_STEPS;
    localparam int SW = TAG_W + 3 + 45;

    // Stage 1: magnitudes and signs.
    logic                 v1_reg;
    logic [2:0][IN_W-1:0] mag1_reg;
    logic [2:0]           neg1_reg;
    logic [TAG_W-1:0]     tag1_reg;
    // Stage 2: leading-one position.
    logic                 v2_reg;
    logic [2:0][IN_W-1:0] mag2_reg;
    logic [2:0]           neg2_reg;
    logic [TAG_W-1:0]     tag2_reg;
    logic [PW-1:0]        p2_reg;
    // Stage 3: scaled magnitudes.
    logic                 v3_reg;
    logic [SW-1:0]        side3_reg;
    // Stage 4: squares.
    logic                 v4_reg;
    logic [SW-1:0]        side4_reg;
    logic [2:0][29:0]     sq4_reg;
    // Newton chain, element 0 is the seed stage.
    logic                 vn [NS+1];
    logic [SW-1:0]        side_n [NS+1];
    logic [31:0]          s_n [NS+1];
    logic [15:0]          y_n [NS+1];
    // Output stages.
    logic                 v6_reg;
    logic [SW-1:0]        side6_reg;
    logic [2:0][30:0]     np6_reg;
    logic                 v7_reg;
    logic [2:0][15:0]     out7_reg;
    logic [TAG_W-1:0]     tag7_reg;

    logic [2:0][IN_W-1:0] mag_c;
    logic [2:0]           neg_c;
    logic [IN_W-1:0]      or_c;
    logic [PW-1:0]        p_c;
    logic [2:0][14:0]     sm_c;
    logic [2:0][29:0]     sq_c;
    logic [31:0]          s_c;
    logic [15:0]          seed_c;
    logic [2:0][14:0]     sm4;
    logic [2:0][30:0]     np_c;
    logic [2:0][14:0]     sm_last;
    logic [2:0]           neg6;
    logic [2:0][15:0]     out_c;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg_c[i] = in_vec[i][IN_W-1];
            mag_c[i] = neg_c[i] ? (IN_W'(0) - in_vec[i]) : in_vec[i];
        end
    end

    // The OR of the magnitudes has its top bit where the largest one has.
    always_comb
    begin
        or_c = mag1_reg[0] | mag1_reg[1] | mag1_reg[2];
        p_c  = '0;
        for (int i = 0; i < IN_W; i++)
        begin
            if (or_c[i])
            begin
                p_c = PW'(i);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [IN_W+14:0] wide;
            wide = {15'd0, mag2_reg[i]} << (PW'(14) - p2_reg);
            if (p2_reg > PW'(14))
            begin
                sm_c[i] = 15'(mag2_reg[i] >> (p2_reg - PW'(14)));
            end
            else
            begin
                sm_c[i] = wide[14:0];
            end
        end
    end

    always_comb
    begin
        sm4 = side3_reg[44:0];
        for (int i = 0; i < 3; i++)
        begin
            sq_c[i] = {15'd0, sm4[i]} * {15'd0, sm4[i]};
        end
        s_c = {2'b00, sq4_reg[0]} + {2'b00, sq4_reg[1]} + {2'b00, sq4_reg[2]};
        priority if (!s_c[31] && !s_c[30] && !s_c[29])
            seed_c = bpps_pkg::SEED_LT_29;
        else if (!s_c[31] && !s_c[30])
            seed_c = bpps_pkg::SEED_LT_30;
        else if (!s_c[31])
            seed_c = bpps_pkg::SEED_LT_31;
        else
            seed_c = bpps_pkg::SEED_HIGH;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vn[0]  <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            vn[0]  <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag1_reg  <= mag_c;
            neg1_reg  <= neg_c;
            tag1_reg  <= in_tag;
            mag2_reg  <= mag1_reg;
            neg2_reg  <= neg1_reg;
            tag2_reg  <= tag1_reg;
            p2_reg    <= p_c;
            side3_reg <= {tag2_reg, neg2_reg, sm_c};
            side4_reg <= side3_reg;
            sq4_reg   <= sq_c;
            side_n[0] <= side4_reg;
            s_n[0]    <= s_c;
            y_n[0]    <= seed_c;
        end
    end

    // One Newton step in three stages: y*y, s*y*y, then y*(1.5 - q).
    for (genvar k = 0; k < NS; k++)
    begin : g_newton
        logic          va_reg;
        logic          vb_reg;
        logic [SW-1:0] sda_reg;
        logic [SW-1:0] sdb_reg;
        logic [31:0]   sa_reg;
        logic [31:0]   sb_reg;
        logic [31:0]   yya_reg;
        logic [15:0]   ya_reg;
        logic [15:0]   yb_reg;
        logic [63:0]   prod_reg;
        logic [19:0]   q;
        logic [15:0]   term;
        logic [31:0]   t;
        logic [16:0]   ny;

        assign q    = prod_reg[63:44];
        assign term = (q >= 20'(bpps_pkg::THREE_HALVES)) ? 16'd0
                    : 16'(20'(bpps_pkg::THREE_HALVES) - q);
        assign t    = {16'd0, yb_reg} * {16'd0, term};
        assign ny   = t[31:15];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                va_reg  <= 1'b0;
                vb_reg  <= 1'b0;
                vn[k+1] <= 1'b0;
            end
            else if (en)
            begin
                va_reg  <= vn[k];
                vb_reg  <= va_reg;
                vn[k+1] <= vb_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                yya_reg     <= {16'd0, y_n[k]} * {16'd0, y_n[k]};
                ya_reg      <= y_n[k];
                sa_reg      <= s_n[k];
                sda_reg     <= side_n[k];
                prod_reg    <= {32'd0, sa_reg} * {32'd0, yya_reg};
                yb_reg      <= ya_reg;
                sb_reg      <= sa_reg;
                sdb_reg     <= sda_reg;
                y_n[k+1]    <= ny[16] ? 16'hFFFF : ny[15:0];
                s_n[k+1]    <= sb_reg;
                side_n[k+1] <= sdb_reg;
            end
        end
    end

    always_comb
    begin
        sm_last = side_n[NS][44:0];
        neg6    = side6_reg[47:45];
        for (int i = 0; i < 3; i++)
        begin
            logic [15:0] n;
            np_c[i] = {16'd0, sm_last[i]} * {15'd0, y_n[NS]};
            n       = np6_reg[i][30:15];
            if (n > bpps_pkg::UNIT_Q14)
            begin
                n = bpps_pkg::UNIT_Q14;
            end
            out_c[i] = neg6[i] ? (16'd0 - n) : n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v6_reg <= vn[NS];
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side6_reg <= side_n[NS];
            np6_reg   <= np_c;
            out7_reg  <= out_c;
            tag7_reg  <= side6_reg[SW-1:48];
        end
    end

    assign out_valid = v7_reg;
    assign out_vec   = out7_reg;
    assign out_tag   = tag7_reg;

endmodule

`default_nettype wire

[hdl/bpps_back.sv]
`timescale 1ns / 1ps
`default_nettype none

// Shading pipeline: normalizes L and V, forms H, takes the dot products,
// raises the specular term to its power and mixes the three channels.
// The whole pipeline advances together whenever the output register can move.
module bpps_back #(
    parameter int COORD_WIDTH = bpps_pkg::COORD_WIDTH_DEF,
    parameter int FE_W        = 48
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [FE_W-1:0]        in_data,
    input  wire bpps_pkg::color_t       color,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [23:0]                 m_tdata
);

    localparam int NW = bpps_pkg::NORMAL_W;
    localparam int DW = COORD_WIDTH + 1;
    localparam int SP = bpps_pkg::SPEC_POWER;

    logic en;

    logic [2:0][DW-1:0] ld;
    logic [2:0][DW-1:0] vd;
    logic               l_valid;
    logic               v_valid;
    logic [2:0][15:0]   l_vec;
    logic [2:0][15:0]   v_vec;
    logic [31:0]        l_tag;
    logic [15:0]        v_tag;

    logic               va_reg;
    logic [2:0][16:0]   hsa_reg;
    logic [2:0][31:0]   npa_reg;
    logic [47:0]        na_reg;
    logic               vb_reg;
    logic [2:0][16:0]   hsb_reg;
    logic [31:0]        db_reg;
    logic [47:0]        nb_reg;

    logic               h_valid;
    logic [2:0][15:0]   h_vec;
    logic [79:0]        h_tag;

    logic               v1_reg;
    logic [2:0][31:0]   hp1_reg;
    logic               dneg1_reg;
    logic [30:0]        dabs1_reg;
    logic               v2_reg;
    logic [31:0]        sd2_reg;
    logic [30:0]        d28_2_reg;

    logic               vs [SP];
    logic [16:0]        f_s [SP];
    logic [16:0]        p_s [SP];
    logic [16:0]        df_s [SP];

    logic               vc_reg;
    logic [2:0][24:0]   cd_reg;
    logic [24:0]        sp_reg;
    logic [2:0][19:0]   base_reg;
    logic               ov_reg;
    logic [23:0]        pix_reg;

    logic [2:0][16:0]   hs_c;
    logic [2:0][31:0]   np_c;
    logic [31:0]        d_c;
    logic [2:0][31:0]   hp_c;
    logic [31:0]        dh;
    logic [31:0]        sd_c;
    logic [63:0]        dq_c;
    logic [16:0]        f_c;
    logic [2:0][7:0]    col;
    logic [2:0][24:0]   cd_c;
    logic [2:0][19:0]   base_c;
    logic [23:0]        pix_c;

    assign en       = !ov_reg || m_tready;
    assign in_ready = en;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ld[i] = in_data[3*NW + DW*i +: DW];
            vd[i] = in_data[3*NW + 3*DW + DW*i +: DW];
        end
    end

    // The normal rides along as tags: x and y with L, z with V.
    bpps_norm #(.IN_W(DW), .TAG_W(32)) u_norm_l (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .in_vec   (ld),
        .in_tag   (in_data[31:0]),
        .out_valid(l_valid),
        .out_vec  (l_vec),
        .out_tag  (l_tag)
    );

    bpps_norm #(.IN_W(DW), .TAG_W(16)) u_norm_v (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .in_vec   (vd),
        .in_tag   (in_data[47:32]),
        .out_valid(v_valid),
        .out_vec  (v_vec),
        .out_tag  (v_tag)
    );

    always_comb
    begin
        logic [47:0] n;
        n = {v_tag, l_tag};
        for (int i = 0; i < 3; i++)
        begin
            hs_c[i] = {l_vec[i][15], l_vec[i]} + {v_vec[i][15], v_vec[i]};
            np_c[i] = 32'($signed(n[NW*i +: NW]) * $signed(l_vec[i]));
        end
        d_c = npa_reg[0] + npa_reg[1] + npa_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= l_valid && v_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hsa_reg <= hs_c;
            npa_reg <= np_c;
            na_reg  <= {v_tag, l_tag};
            hsb_reg <= hsa_reg;
            db_reg  <= d_c;
            nb_reg  <= na_reg;
        end
    end

    bpps_norm #(.IN_W(17), .TAG_W(80)) u_norm_h (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (vb_reg),
        .in_vec   (hsb_reg),
        .in_tag   ({db_reg, nb_reg}),
        .out_valid(h_valid),
        .out_vec  (h_vec),
        .out_tag  (h_tag)
    );

    always_comb
    begin
        dh = h_tag[79:48];
        for (int i = 0; i < 3; i++)
        begin
            hp_c[i] = 32'($signed(h_vec[i]) * $signed(h_tag[NW*i +: NW]));
        end
        sd_c = hp1_reg[0] + hp1_reg[1] + hp1_reg[2];
        dq_c = {33'd0, dabs1_reg} * {32'd0, bpps_pkg::RECIP5};
        f_c  = (!sd2_reg[31] && (sd2_reg != 32'd0)) ? sd2_reg[30:14] : 17'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vs[0]  <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= h_valid;
            v2_reg <= v1_reg;
            vs[0]  <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hp1_reg   <= hp_c;
            dneg1_reg <= dh[31];
            dabs1_reg <= dh[31] ? 31'(32'd0 - dh) : dh[30:0];
            sd2_reg   <= sd_c;
            d28_2_reg <= dneg1_reg ? 31'(dq_c[63:34]) : dabs1_reg;
            f_s[0]    <= f_c;
            p_s[0]    <= (f_c > bpps_pkg::SPEC_CAP) ? bpps_pkg::SPEC_CAP : f_c;
            df_s[0]   <= d28_2_reg[30:14];
        end
    end

    // Repeated multiply for the specular power, one step per stage.
    for (genvar k = 1; k < SP; k++)
    begin : g_power
        logic [33:0] pf;
        logic [19:0] sh;

        assign pf = {17'd0, p_s[k-1]} * {17'd0, f_s[k-1]};
        assign sh = pf[33:14];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vs[k] <= 1'b0;
            end
            else if (en)
            begin
                vs[k] <= vs[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                f_s[k]  <= f_s[k-1];
                df_s[k] <= df_s[k-1];
                p_s[k]  <= (sh > 20'(bpps_pkg::SPEC_CAP)) ? bpps_pkg::SPEC_CAP : sh[16:0];
            end
        end
    end

    always_comb
    begin
        col = {color.blue, color.green, color.red};
        for (int i = 0; i < 3; i++)
        begin
            logic [26:0] sum;
            cd_c[i]   = 25'(col[i]) * 25'(df_s[SP-1]);
            base_c[i] = bpps_pkg::color_base(col[i]);
            sum       = 27'(cd_reg[i]) + 27'(sp_reg) + 27'(base_reg[i]);
            pix_c[8*i +: 8] = (sum[26:22] != 5'd0) ? 8'hFF : sum[21:14];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            vc_reg <= vs[SP-1];
            ov_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cd_reg   <= cd_c;
            sp_reg   <= 25'(p_s[SP-1]) * 25'(bpps_pkg::SPEC_SCALE);
            base_reg <= base_c;
            pix_reg  <= pix_c;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = pix_reg;

endmodule

`default_nettype wire

[hdl/blinn_phong_pixel_shader.sv]
// Blinn-Phong pixel shader.
// Each slave-side transaction carries one pixel: a Q1.14 unit normal and the
// Q8.8 positions of the shaded point, the light and the camera. Each
// master-side transaction returns the shaded red, green and blue channels.
// The material color sits in three registers written through cfg_we,
// cfg_index and cfg_data (index 0 red, 1 green, 2 blue; other indexes are
// ignored). Write them only while no pixel is in flight.
// Throughput is one pixel per clock while m_tready stays high. A pixel passes
// through the input register, the queue and the shading pipeline, whose depth
// is set mostly by the two chained normalizers (19 stages each, four
// three-stage Newton steps inside) and the 13-stage specular power chain.
// When the receiver holds m_tready low, the result stays in the output
// register and the shading pipeline freezes; the four-entry queue and the
// input register keep taking transactions until they fill, and then s_tready
// drops. Reset clears all valid flags and returns the colors to 100.
`timescale 1ns / 1ps
`default_nettype none

module blinn_phong_pixel_shader #(
    parameter int COORD_WIDTH = bpps_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // normal_x, normal_y, normal_z, surface_x, surface_y, surface_z,
    // light_x, light_y, light_z, camera_x, camera_y, camera_z, zero fill
    input  wire logic [((48 + 9*COORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // pixel_red, pixel_green, pixel_blue
    output logic [23:0]                                 m_tdata,
    input  wire logic                                   cfg_we,
    input  wire bpps_pkg::cfg_index_t                   cfg_index,
    input  wire logic [7:0]                             cfg_data
);

    localparam int IN_W = ((48 + 9*COORD_WIDTH + 7) / 8) * 8;
    localparam int FE_W = 48 + 6 * (COORD_WIDTH + 1);

    bpps_pkg::color_t color_reg;

    logic            fe_valid;
    logic            fe_ready;
    logic [FE_W-1:0] fe_data;
    logic            q_valid;
    logic            q_ready;
    logic [FE_W-1:0] q_data;

    // Material color registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg.red   <= bpps_pkg::COLOR_RESET;
            color_reg.green <= bpps_pkg::COLOR_RESET;
            color_reg.blue  <= bpps_pkg::COLOR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bpps_pkg::CFG_RED:   color_reg.red   <= cfg_data;
                bpps_pkg::CFG_GREEN: color_reg.green <= cfg_data;
                bpps_pkg::CFG_BLUE:  color_reg.blue  <= cfg_data;
                default:             color_reg       <= color_reg;
            endcase
        end
    end

    // Input register: takes transactions and forms the direction vectors.
    bpps_front #(
        .COORD_WIDTH(COORD_WIDTH),
        .IN_W       (IN_W),
        .FE_W       (FE_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .out_valid(fe_valid),
        .out_ready(fe_ready),
        .out_data (fe_data)
    );

    // Queue decoupling intake from the shading pipeline.
    bpps_fifo #(
        .WIDTH(FE_W),
        .DEPTH(bpps_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(fe_valid),
        .push_ready(fe_ready),
        .push_data (fe_data),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_data  (q_data)
    );

    // Shading pipeline with its output register.
    bpps_back #(
        .COORD_WIDTH(COORD_WIDTH),
        .FE_W       (FE_W)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(q_valid),
        .in_ready(q_ready),
        .in_data (q_data),
        .color   (color_reg),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

endmodule

`default_nettype wire

[hdl/bpps_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks for the pixel shader.
module bpps_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    // Pixels accepted but not yet delivered.
    logic [7:0] pending_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 8'(s_tvalid && s_tready) - 8'(m_tvalid && m_tready);
        end
    end

    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pending_reg != 8'd0)
        else $error("result without an accepted pixel");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 8'd0 |-> s_tready)
        else $error("input stalled while nothing is in flight");

endmodule

bind blinn_phong_pixel_shader bpps_checker u_bpps_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

`default_nettype wire

[tb/blinn_phong_pixel_shader_test.sv]
`timescale 1ns / 1ps

// Self-checking bench for the Blinn-Phong pixel shader. Pixels are sent as
// slave-side transactions, and a shading predictor written from the fixed-point
// description computes the expected color of each one. Master-side
// transactions are compared field by field against the oldest prediction.
module blinn_phong_pixel_shader_test;

    localparam int CW = 16;
    localparam int DW = ((48 + 9 * CW + 7) / 8) * 8;
    localparam int DRAIN_CYCLES = 80;
    localparam longint CYCLE_LIMIT = 400000;

    // One pixel: normal, surface, light, camera (three components each).
    typedef struct {
        logic signed [15:0] f [12];
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b1;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic cfg_we = 1'b0;
    bpps_pkg::cfg_index_t cfg_index = bpps_pkg::CFG_RED;
    logic [7:0] cfg_data = '0;

    // Shading state of the predictor and the queue of expected colors.
    logic [7:0] mat_color [3];
    logic [23:0] expected_colors [$];
    int errors = 0;
    int checked = 0;
    longint cycles = 0;

    // Idle percentages for each side; a long hold-off request for the receiver.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int recv_hold_cycles = 0;

    blinn_phong_pixel_shader #(.COORD_WIDTH(CW)) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // Fixed-point normalize: scale the magnitudes into [2^14, 2^15), then
    // refine a reciprocal square root with four Newton steps.
    function automatic void unit_vector(input longint v [3], output longint o [3]);
        longint unsigned mag [3];
        longint unsigned m;
        longint unsigned s;
        longint unsigned y;
        longint unsigned q;
        longint unsigned term;
        longint unsigned n;
        m = 0;
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (v[i] < 0) ? -v[i] : v[i];
            if (mag[i] > m)
                m = mag[i];
        end
        if (m == 0)
        begin
            for (int i = 0; i < 3; i++)
                o[i] = 0;
            return;
        end
        while (m >= 32768)
        begin
            for (int i = 0; i < 3; i++)
                mag[i] >>= 1;
            m >>= 1;
        end
        while (m < 16384)
        begin
            for (int i = 0; i < 3; i++)
                mag[i] <<= 1;
            m <<= 1;
        end
        for (int i = 0; i < 3; i++)
            s += mag[i] * mag[i];
        if (s < (64'd1 << 29))
            y = 26214;
        else if (s < (64'd1 << 30))
            y = 19661;
        else if (s < (64'd1 << 31))
            y = 13926;
        else
            y = 10650;
        for (int k = 0; k < 4; k++)
        begin
            q = (s * (y * y)) >> 44;
            term = (q >= 49152) ? 0 : 49152 - q;
            y = (y * term) >> 15;
            if (y > 65535)
                y = 65535;
        end
        for (int i = 0; i < 3; i++)
        begin
            n = (mag[i] * y) >> 15;
            if (n > 16384)
                n = 16384;
            o[i] = (v[i] < 0) ? -longint'(n) : longint'(n);
        end
    endfunction

    function automatic logic [7:0] channel(input longint unsigned c,
                                           input longint unsigned diff,
                                           input longint unsigned spec);
        longint unsigned sum;
        sum = (c * diff + 150 * spec + ((c << 14) / 5)) >> 14;
        return (sum > 255) ? 8'd255 : sum[7:0];
    endfunction

    function automatic logic [23:0] shade_pixel(input pixel_t p);
        longint nrm [3];
        longint ld [3];
        longint vd [3];
        longint l [3];
        longint vv [3];
        longint hs [3];
        longint h [3];
        longint d;
        longint sd;
        longint unsigned diff;
        longint unsigned spec;
        longint unsigned f;
        spec = 0;
        for (int i = 0; i < 3; i++)
        begin
            nrm[i] = p.f[i];
            ld[i] = longint'(p.f[6 + i]) - p.f[3 + i];
            vd[i] = longint'(p.f[9 + i]) - p.f[3 + i];
        end
        unit_vector(ld, l);
        unit_vector(vd, vv);
        for (int i = 0; i < 3; i++)
            hs[i] = l[i] + vv[i];
        unit_vector(hs, h);
        d = nrm[0] * l[0] + nrm[1] * l[1] + nrm[2] * l[2];
        // Back-facing light is folded over at a fifth of its strength.
        diff = (d < 0) ? longint'(-d) / 5 : d;
        diff >>= 14;
        sd = h[0] * nrm[0] + h[1] * nrm[1] + h[2] * nrm[2];
        if (sd > 0)
        begin
            f = sd >> 14;
            spec = (f > 65536) ? 65536 : f;
            for (int k = 1; k < 14; k++)
            begin
                spec = (spec * f) >> 14;
                if (spec > 65536)
                    spec = 65536;
            end
        end
        return {channel(mat_color[2], diff, spec), channel(mat_color[1], diff, spec),
                channel(mat_color[0], diff, spec)};
    endfunction

    // Cycle counter with the run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t timeout with %0d colors outstanding", $time, expected_colors.size());
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: random back-pressure plus the occasional long hold-off.
    always @(posedge clk)
    begin
        if (recv_hold_cycles > 0)
        begin
            recv_hold_cycles <= recv_hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Checker: every master-side transaction against the oldest prediction.
    always @(posedge clk)
    begin
        logic [23:0] exp_c;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_colors.size() == 0)
            begin
                errors++;
                $display("%0t unexpected pixel: expected none, actual %h", $time, m_tdata);
            end
            else
            begin
                exp_c = expected_colors.pop_front();
                checked++;
                for (int ch = 0; ch < 3; ch++)
                    if (exp_c[ch*8 +: 8] !== m_tdata[ch*8 +: 8])
                    begin
                        errors++;
                        $display("%0t channel %0d mismatch: expected %0d, actual %0d",
                                 $time, ch, exp_c[ch*8 +: 8], m_tdata[ch*8 +: 8]);
                    end
            end
        end
    end

    // The valid line stays high between back-to-back transactions and only
    // drops while the sender idles or waits for the pipeline to drain.
    task automatic send_pixel(input pixel_t p);
        logic [DW-1:0] packed_data;
        packed_data = '0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        for (int i = 0; i < 12; i++)
            packed_data[i*16 +: 16] = p.f[i];
        s_tdata <= packed_data;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        // Predict at acceptance, with the color that is in force.
        expected_colors.push_back(shade_pixel(p));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_colors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_we high; the caller drops it after its last write.
    task automatic write_color(input bpps_pkg::cfg_index_t idx, input logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        if (idx <= bpps_pkg::CFG_BLUE)
            mat_color[idx] = val;
    endtask

    task automatic set_material(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        wait_drained();
        write_color(bpps_pkg::CFG_RED, r);
        write_color(bpps_pkg::CFG_GREEN, g);
        write_color(bpps_pkg::CFG_BLUE, b);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [15:0] any_word();
        return 16'($urandom_range(65535));
    endfunction

    // Mostly a unit-length normal, sometimes an arbitrary one.
    function automatic pixel_t random_pixel();
        pixel_t p;
        longint v [3];
        longint o [3];
        int spread;
        spread = ($urandom_range(3) == 0) ? 32767 : 2000;
        for (int i = 0; i < 3; i++)
            v[i] = $signed($urandom_range(8191)) - 4096;
        unit_vector(v, o);
        for (int i = 0; i < 3; i++)
            p.f[i] = ($urandom_range(9) == 0) ? any_word() : 16'(o[i]);
        for (int i = 3; i < 12; i++)
            p.f[i] = (spread == 32767) ? any_word()
                     : 16'($signed($urandom_range(2 * spread)) - spread);
        return p;
    endfunction

    task automatic test_directed();
        pixel_t p;
        // Zero-length light vector, then opposite light and view, then the extremes.
        for (int c = 0; c < 24; c++)
        begin
            for (int i = 0; i < 12; i++)
                p.f[i] = 0;
            p.f[2] = 16384;
            case (c % 8)
                0: p.f[11] = 256;
                1: begin p.f[8] = 256; p.f[11] = -256; end
                2: begin p.f[8] = 256; p.f[11] = 256; end
                3: begin p.f[2] = -16384; p.f[8] = 256; p.f[11] = 256; end
                4: for (int i = 0; i < 12; i++) p.f[i] = (i < 3) ? 16384 : 32767;
                5: for (int i = 0; i < 12; i++) p.f[i] = (i < 3) ? -16384 : -32768;
                6: begin p.f[5] = -32768; p.f[8] = 32767; p.f[11] = 32767; end
                default: begin p.f[0] = 16'h7fff; p.f[1] = 16'h8000; p.f[8] = 32767;
                               p.f[3] = 16'h5555; p.f[10] = 16'haaaa; end
            endcase
            send_pixel(p);
        end
    endtask

    task automatic test_random(input int count);
        for (int k = 0; k < count; k++)
            send_pixel(random_pixel());
    endtask

    // Long receiver hold-off: more pixels than the pipeline holds, so the
    // queue fills up and s_tready must drop.
    task automatic test_backpressure();
        recv_hold_cycles = 300;
        test_random(120);
        wait_drained();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        for (int i = 0; i < 3; i++)
            mat_color[i] = 8'd100;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 9;
        recv_idle_pct = 59;
        test_directed();
        set_material(8'd255, 8'd255, 8'd255);
        test_directed();
        set_material(8'd0, 8'd0, 8'd0);
        test_random(100);
        wait_drained();
        // An out-of-range index must leave the colors alone.
        write_color(bpps_pkg::cfg_index_t'(3), 8'd7);
        cfg_we <= 1'b0;

        set_material(8'd17, 8'd200, 8'd90);
        test_random(550);
        test_backpressure();

        send_idle_pct = 59;
        recv_idle_pct = 9;
        set_material(8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
        test_random(550);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_material(8'd255, 8'd0, 8'd128);
        test_random(600);
        wait_drained();

        $display("Covered %0d pixels: directed edge cases, random geometry, material extremes,",
                 checked);
        $display("random idling on both sides and a long output stall.");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
